### design/running_median_dual_heap_assert.svh
// Assertion macros for the running median block.
`ifndef RUNNING_MEDIAN_DUAL_HEAP_ASSERT_SVH
`define RUNNING_MEDIAN_DUAL_HEAP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge outside reset
`define RMH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property checked only at edges where a condition holds
`define RMH_ASSERT_WHEN(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

`else

`define RMH_ASSERT(label, prop, msg)
`define RMH_ASSERT_WHEN(label, cond, prop, msg)

`endif

`endif

### design/rmh_pkg.sv
// Shared constants, beat types and chain command types for the running median.
`timescale 1ns / 1ps

package rmh_pkg;

    localparam int CAPACITY    = 4096;
    localparam int CHAIN_DEPTH = CAPACITY / 2;
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int LEVEL_W     = $clog2(CHAIN_DEPTH + 1);

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

    typedef logic signed [DATA_W-1:0] t_sample;

    typedef struct packed {
        t_sample sample;
        logic    restart;
    } t_in_beat;

    typedef struct packed {
        t_sample            median;
        logic [COUNT_W-1:0] item_count;
        logic               count_is_odd;
        logic               full_drop;
    } t_out_beat;

    // Operation broadcast to every cell of a chain
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP,
        OP_CLEAR
    } t_chain_op;

    typedef struct packed {
        t_chain_op op;
        t_sample   key;
    } t_chain_cmd;

    // What a cell shows its neighbors
    typedef struct packed {
        logic    valid;
        logic    place;
        t_sample value;
    } t_cell_link;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_PLAN,
        S_INSERT,
        S_DONE
    } t_state;

endpackage

### design/rmh_cell.sv
// One cell of a sorted shift chain: holds one sample and trades with its neighbors.
`timescale 1ns / 1ps

module rmh_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rmh_pkg::t_chain_cmd i_cmd,
    input  logic                i_desc,
    input  rmh_pkg::t_cell_link i_prev,
    input  rmh_pkg::t_cell_link i_next,
    output rmh_pkg::t_cell_link o_link
);
    import rmh_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_sample r_value;
    t_sample n_value;
    logic    w_before;
    logic    w_place;

    // Key sorts ahead of this cell's sample (strict, so ties stay behind)
    always_comb begin
        if (i_desc) begin
            w_before = $signed(i_cmd.key) > $signed(r_value);
        end else begin
            w_before = $signed(i_cmd.key) < $signed(r_value);
        end
        w_place = !r_valid || w_before;
    end

    // Next value: insert shifts the tail back one cell, pop pulls the whole row forward, clear empties the cell
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        case (i_cmd.op)
            OP_INSERT: begin
                if (w_place) begin
                    n_valid = r_valid | i_prev.valid;
                    n_value = i_prev.place ? i_prev.value : i_cmd.key;
                end
            end
            OP_POP: begin
                n_valid = i_next.valid;
                n_value = i_next.value;
            end
            OP_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.valid = r_valid;
    assign o_link.place = w_place;
    assign o_link.value = r_value;

endmodule

### design/rmh_chain.sv
// Row of cells kept sorted; cell 0 holds the extreme sample of the half.
`timescale 1ns / 1ps

module rmh_chain (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rmh_pkg::t_chain_cmd i_cmd,
    input  logic                i_desc,
    output rmh_pkg::t_sample    o_top
);
    import rmh_pkg::*;

    t_cell_link w_link [CHAIN_DEPTH];
    t_cell_link w_head;
    t_cell_link w_tail;

    // Ends of the row: the head never takes the key, the tail is empty
    assign w_head = '{valid: 1'b1, place: 1'b0, value: '0};
    assign w_tail = '{valid: 1'b0, place: 1'b1, value: '0};

    for (genvar g = 0; g < CHAIN_DEPTH; g++) begin : g_cell
        t_cell_link w_prev;
        t_cell_link w_next;

        if (g == 0) begin : g_first
            assign w_prev = w_head;
        end else begin : g_mid_prev
            assign w_prev = w_link[g-1];
        end

        if (g == CHAIN_DEPTH - 1) begin : g_last
            assign w_next = w_tail;
        end else begin : g_mid_next
            assign w_next = w_link[g+1];
        end

        rmh_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (i_cmd),
            .i_desc  (i_desc),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_link  (w_link[g])
        );
    end

    assign o_top = w_link[0].value;

endmodule

### design/running_median_dual_heap.sv
// Top level: item sequencer, two sorted cell chains and the result register.
`timescale 1ns / 1ps

// Running median over signed 32-bit samples, up to 4096 held. The lower half
// of the samples sits in a descending cell chain and the upper half in an
// ascending one; each chain shifts as a whole, so an insert, a pop or an
// empty-out moves every cell at once regardless of fill. From acceptance an
// item goes through accepting, routing the sample and loading the result,
// with one more step either when restart is set or when the sample has to
// trade places with the top of the other half (never both, since a restart
// leaves the other half empty); the load waits while a result is stalled on
// the output. The sequencer issues at most one operation per chain per cycle.
// Each result beat carries the lower median, the count held, an odd-count
// flag, and a drop flag raised when the store was already full and the sample
// was discarded. The input stalls while an item is in flight; the next item is
// taken while a result still waits on the output.
module running_median_dual_heap (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rmh_pkg::t_in_beat i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rmh_pkg::t_out_beat o_out_beat
);
    import rmh_pkg::*;

`include "running_median_dual_heap_assert.svh"

    t_state             r_state;
    t_state             n_state;
    t_sample            r_key;
    t_sample            n_key;
    logic               r_to_upper;
    logic               n_to_upper;
    logic               r_drop;
    logic               n_drop;
    logic [LEVEL_W-1:0] r_nl;
    logic [LEVEL_W-1:0] n_nl;
    logic [LEVEL_W-1:0] r_nu;
    logic [LEVEL_W-1:0] n_nu;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_beat          r_out_beat;
    t_out_beat          n_out_beat;

    t_chain_cmd         w_lower_cmd;
    t_chain_cmd         w_upper_cmd;
    t_sample            w_lower_top;
    t_sample            w_upper_top;
    logic [COUNT_W-1:0] w_total;

    assign w_total = COUNT_W'(r_nl) + COUNT_W'(r_nu);

    // Lower half: largest first
    rmh_chain u_lower (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_lower_cmd),
        .i_desc  (1'b1),
        .o_top   (w_lower_top)
    );

    // Upper half: smallest first
    rmh_chain u_upper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_upper_cmd),
        .i_desc  (1'b0),
        .o_top   (w_upper_top)
    );

    // Sequencer: next state, chain commands, counts and result
    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_to_upper  = r_to_upper;
        n_drop      = r_drop;
        n_nl        = r_nl;
        n_nu        = r_nu;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_beat  = r_out_beat;
        w_lower_cmd = '{op: OP_HOLD, key: r_key};
        w_upper_cmd = '{op: OP_HOLD, key: r_key};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key   = i_in_beat.sample;
                    n_drop  = 1'b0;
                    n_state = i_in_beat.restart ? S_CLEAR : S_PLAN;
                end
            end
            S_CLEAR: begin
                w_lower_cmd.op = OP_CLEAR;
                w_upper_cmd.op = OP_CLEAR;
                n_nl           = '0;
                n_nu           = '0;
                n_state        = S_PLAN;
            end
            S_PLAN: begin
                if (w_total == FULL_COUNT) begin
                    n_drop  = 1'b1;
                    n_state = S_DONE;
                end else if (r_nl == r_nu) begin
                    // Lower half grows: it takes the sample or the upper top
                    if (r_nu != '0 && $signed(r_key) > $signed(w_upper_top)) begin
                        w_lower_cmd = '{op: OP_INSERT, key: w_upper_top};
                        w_upper_cmd.op = OP_POP;
                        n_nl       = r_nl + LEVEL_W'(1);
                        n_nu       = r_nu - LEVEL_W'(1);
                        n_to_upper = 1'b1;
                        n_state    = S_INSERT;
                    end else begin
                        w_lower_cmd.op = OP_INSERT;
                        n_nl           = r_nl + LEVEL_W'(1);
                        n_state        = S_DONE;
                    end
                end else begin
                    // Upper half grows: it takes the sample or the lower top
                    if ($signed(r_key) < $signed(w_lower_top)) begin
                        w_upper_cmd = '{op: OP_INSERT, key: w_lower_top};
                        w_lower_cmd.op = OP_POP;
                        n_nu       = r_nu + LEVEL_W'(1);
                        n_nl       = r_nl - LEVEL_W'(1);
                        n_to_upper = 1'b0;
                        n_state    = S_INSERT;
                    end else begin
                        w_upper_cmd.op = OP_INSERT;
                        n_nu           = r_nu + LEVEL_W'(1);
                        n_state        = S_DONE;
                    end
                end
            end
            S_INSERT: begin
                if (r_to_upper) begin
                    w_upper_cmd.op = OP_INSERT;
                    n_nu           = r_nu + LEVEL_W'(1);
                end else begin
                    w_lower_cmd.op = OP_INSERT;
                    n_nl           = r_nl + LEVEL_W'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid             = 1'b1;
                    n_out_beat.median       = w_lower_top;
                    n_out_beat.item_count   = w_total;
                    n_out_beat.count_is_odd = w_total[0];
                    n_out_beat.full_drop    = r_drop;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nl        <= '0;
            r_nu        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nl        <= n_nl;
            r_nu        <= n_nu;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_to_upper <= n_to_upper;
        r_drop     <= n_drop;
        r_out_beat <= n_out_beat;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    // Halves stay balanced between items
    `RMH_ASSERT_WHEN(a_balanced, r_state == S_IDLE, (r_nu <= r_nl) && (r_nl <= r_nu + LEVEL_W'(1)), "halves out of balance")
    // Never more held than the store allows
    `RMH_ASSERT(a_bounded, w_total <= FULL_COUNT, "sample count above capacity")
    // A dropped sample is only reported on a full store
    `RMH_ASSERT_WHEN(a_drop_full, r_out_valid && r_out_beat.full_drop, r_out_beat.item_count == FULL_COUNT, "drop reported below capacity")
    // An accepted beat always leaves idle
    `RMH_ASSERT_WHEN(a_accept_busy, i_in_valid && !o_in_stall, ##1 (r_state != S_IDLE), "sequencer stayed idle after accept")

endmodule
